// File: sv/okvt_pkg.sv
// ----------------------------------------------------------------------------
// Ordered key-value table package
// Shared sizes, command codes and the beat types of both channels.
// ----------------------------------------------------------------------------
package okvt_pkg;

    localparam int DEPTH = 16;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int POS_W = 4;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMD_W = 3;

    localparam logic [CMD_W-1:0] CMD_SET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ACCESS = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key_in;
        logic [VAL_W-1:0] value_in;
        logic [POS_W-1:0] position;
    } t_in;

    typedef struct packed {
        logic             found;
        logic [KEY_W-1:0] key_out;
        logic [VAL_W-1:0] value_out;
        logic [IDX_W-1:0] index_out;
        logic [CNT_W-1:0] count_out;
        logic             full_reject;
    } t_out;

endpackage

// File: sv/okvt_table.sv
// ----------------------------------------------------------------------------
// Ordered key-value table storage and command logic
// Holds the entries in insertion order, compares all keys in parallel and
// applies one command per enabled cycle, giving the result beat at once.
// ----------------------------------------------------------------------------
module okvt_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  okvt_pkg::t_in i_item,
    output okvt_pkg::t_out o_result
);

    logic [okvt_pkg::KEY_W-1:0] r_keys [okvt_pkg::DEPTH];
    logic [okvt_pkg::VAL_W-1:0] r_vals [okvt_pkg::DEPTH];
    logic [okvt_pkg::IDX_W-1:0] r_idxs [okvt_pkg::DEPTH];
    logic [okvt_pkg::CNT_W-1:0] r_count;
    logic [okvt_pkg::CNT_W-1:0] n_count;

    logic                       hit;
    logic [okvt_pkg::IDX_W-1:0] hit_idx;
    logic                       full;
    logic                       wr_en;
    logic [okvt_pkg::IDX_W-1:0] wr_idx;
    logic [okvt_pkg::KEY_W-1:0] wr_key;
    logic [okvt_pkg::VAL_W-1:0] wr_val;
    logic [okvt_pkg::IDX_W-1:0] wr_ix;
    logic                       del_en;
    logic [okvt_pkg::VAL_W-1:0] ins_val;
    logic                       pos_ok;

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = okvt_pkg::DEPTH - 1; i >= 0; i--) begin
            if ((okvt_pkg::CNT_W'(i) < r_count) && (r_keys[i] == i_item.key_in)) begin
                hit     = 1'b1;
                hit_idx = okvt_pkg::IDX_W'(i);
            end
        end
    end

    assign full   = (r_count == okvt_pkg::CNT_W'(okvt_pkg::DEPTH));
    assign pos_ok = (okvt_pkg::CNT_W'(i_item.position) < r_count);

    always_comb begin
        o_result  = '0;
        n_count   = r_count;
        wr_en     = 1'b0;
        wr_idx    = hit_idx;
        wr_key    = i_item.key_in;
        wr_val    = i_item.value_in;
        wr_ix     = r_idxs[hit_idx];
        del_en    = 1'b0;
        ins_val   = (i_item.cmd == okvt_pkg::CMD_SET) ? i_item.value_in : '0;
        unique case (i_item.cmd)
            okvt_pkg::CMD_SET, okvt_pkg::CMD_ACCESS: begin
                o_result.key_out = i_item.key_in;
                if (hit) begin
                    o_result.found     = 1'b1;
                    o_result.index_out = r_idxs[hit_idx];
                    if (i_item.cmd == okvt_pkg::CMD_SET) begin
                        wr_en              = 1'b1;
                        o_result.value_out = i_item.value_in;
                    end else begin
                        o_result.value_out = r_vals[hit_idx];
                    end
                end else if (full) begin
                    o_result.full_reject = 1'b1;
                end else begin
                    wr_en              = 1'b1;
                    wr_idx             = r_count[okvt_pkg::IDX_W-1:0];
                    wr_val             = ins_val;
                    wr_ix              = r_count[okvt_pkg::IDX_W-1:0];
                    n_count            = r_count + 1'b1;
                    o_result.value_out = ins_val;
                    o_result.index_out = r_count[okvt_pkg::IDX_W-1:0];
                end
            end
            okvt_pkg::CMD_GET, okvt_pkg::CMD_DELETE: begin
                o_result.key_out = i_item.key_in;
                if (hit) begin
                    o_result.found     = 1'b1;
                    o_result.value_out = r_vals[hit_idx];
                    o_result.index_out = r_idxs[hit_idx];
                    if (i_item.cmd == okvt_pkg::CMD_DELETE) begin
                        del_en  = 1'b1;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            okvt_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            okvt_pkg::CMD_READ: begin
                if (pos_ok) begin
                    o_result.found     = 1'b1;
                    o_result.key_out   = r_keys[i_item.position[okvt_pkg::IDX_W-1:0]];
                    o_result.value_out = r_vals[i_item.position[okvt_pkg::IDX_W-1:0]];
                    o_result.index_out = r_idxs[i_item.position[okvt_pkg::IDX_W-1:0]];
                end
            end
            default: begin
            end
        endcase
        o_result.count_out = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_step) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && wr_en) begin
            r_keys[wr_idx] <= wr_key;
            r_vals[wr_idx] <= wr_val;
            r_idxs[wr_idx] <= wr_ix;
        end
        if (i_step && del_en) begin
            for (int i = 0; i < okvt_pkg::DEPTH - 1; i++) begin
                if (okvt_pkg::IDX_W'(i) >= hit_idx) begin
                    r_keys[i] <= r_keys[i+1];
                    r_vals[i] <= r_vals[i+1];
                    r_idxs[i] <= r_idxs[i+1];
                end
            end
        end
    end

endmodule

// File: sv/ordered_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// Ordered key-value table unit
// Top level: input register, table logic and result register.
// ----------------------------------------------------------------------------
// A command beat (set, get, delete, clear, read_at or access) enters on the
// input channel and each one gives exactly one result beat on the output
// channel, in order. Both channels use valid and ready.
// An accepted beat is held in the input register; when it advances, the table
// compares all sixteen keys in parallel, updates its entries and loads the
// result register in that same cycle, and the result is offered from the
// result register on the output channel.
// Throughput is one command per cycle while the receiver takes results, set by
// the single pass through the parallel key compare and the one-step shift on delete.
// Reset empties the table (the entry count goes to zero) and drops any beat
// in either register; entry contents are not cleared.
// When the receiver stalls, the result is held, one more command waits in
// the input register, and then input ready falls until the result is taken.
// ----------------------------------------------------------------------------
module ordered_key_value_table_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  okvt_pkg::t_in  i_in_data,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output okvt_pkg::t_out o_out_data
);

    logic           r_in_valid;
    okvt_pkg::t_in  r_in;
    logic           r_out_valid;
    okvt_pkg::t_out r_out;
    okvt_pkg::t_out result;
    logic           advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    okvt_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.count_out <= okvt_pkg::CNT_W'(okvt_pkg::DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.full_reject) |->
        (!o_out_data.found && o_out_data.count_out == okvt_pkg::CNT_W'(okvt_pkg::DEPTH)))
        else $error("Rejected insert without a full table or with a match.");

    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("Input ready low without both registers held.");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("Pending command did not reach the result register.");

endmodule
